FILE: hw/rtl/fifs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Feet / inch / fraction split package
// Shared widths, register indexes and the stage-to-stage bundle types.
// ----------------------------------------------------------------------------
package fifs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PREC_W    = 9;
    localparam int NUM_W     = 9;
    localparam int FEET_W    = 12;
    localparam int WHOLE_W   = 32 - FRAC_BITS;

    // Rounded-up reciprocal of three, scaled by 2^WHOLE_W, for the divide by twelve.
    localparam int RECIP3    = (2 ** WHOLE_W + 2) / 3;

    localparam logic [PREC_W-1:0] PREC_MAX = PREC_W'(256);

    typedef enum logic [0:0] {
        REG_DRAW_SCALE = 1'b0,
        REG_FRAC_PREC  = 1'b1
    } t_reg_idx;

    // Everything the reduction stage needs for one item.
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [FEET_W-1:0] feet;
        logic [3:0]        inch;
        logic [NUM_W-1:0]  num;
        logic [PREC_W-1:0] prec;
    } t_split;

endpackage
`default_nettype wire

FILE: hw/rtl/fifs_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scale and split front end
// Four register stages: magnitude, 32x32 product, saturation and feet/inch
// split by reciprocal multiplication, fraction rounding with carry into inches
// and feet.
// ----------------------------------------------------------------------------
module fifs_split
    import fifs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_length_in,
    input  wire logic [31:0]       i_scale,
    input  wire logic [PREC_W-1:0] i_prec,
    output logic                   o_valid,
    output t_split                 o_split
);

    // stage 1: magnitude
    logic              r_v1;
    logic              r_neg1;
    logic [32:0]       r_mag1;
    logic [31:0]       r_scale1;
    logic [PREC_W-1:0] r_prec1;
    // stage 2: product
    logic              r_v2;
    logic              r_neg2;
    logic [64:0]       r_prod2;
    logic [PREC_W-1:0] r_prec2;
    // stage 3: saturation and split
    logic                 r_v3;
    logic                 r_neg3;
    logic                 r_ovf3;
    logic                 r_nz3;
    logic [WHOLE_W-1:0]   r_feet3;
    logic [3:0]           r_inch3;
    logic [FRAC_BITS-1:0] r_frac3;
    logic [PREC_W-1:0]    r_prec3;

    logic [PREC_W-1:0]    n_prec;
    logic [64:0]          sm_full;
    logic [31:0]          limit;
    logic                 ovf;
    logic [31:0]          sm;
    logic [WHOLE_W-1:0]   whole;
    logic [WHOLE_W-3:0]   quarter;
    logic [2*WHOLE_W-3:0] feet_prod;
    logic [WHOLE_W-1:0]   feet_d;
    logic [3:0]           inch_d;
    logic [FRAC_BITS+PREC_W:0] rnd;
    logic [NUM_W-1:0]     num;
    logic [WHOLE_W-1:0]   feet_c;
    logic [3:0]           inch_c;
    logic [NUM_W-1:0]     num_c;

    always_comb begin
        if (i_prec == '0) begin
            n_prec = PREC_W'(1);
        end else if (i_prec > PREC_MAX) begin
            n_prec = PREC_MAX;
        end else begin
            n_prec = i_prec;
        end
    end

    always_comb begin
        sm_full = r_prod2 >> FRAC_BITS;
        limit   = r_neg2 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        ovf     = sm_full > 65'(limit);
        sm      = ovf ? limit : sm_full[31:0];
        whole   = sm[31:FRAC_BITS];
    end

    // Feet are a quarter of the whole inches divided by three; the remainder
    // needs only the low four bits of both sides.
    always_comb begin
        quarter   = whole[WHOLE_W-1:2];
        feet_prod = (2*WHOLE_W-2)'(quarter) * (2*WHOLE_W-2)'(RECIP3);
        feet_d    = WHOLE_W'(feet_prod >> WHOLE_W);
        inch_d    = whole[3:0] - (feet_d[3:0] << 3) - (feet_d[3:0] << 2);
    end

    always_comb begin
        rnd = ((FRAC_BITS+PREC_W+1)'(r_frac3) * (FRAC_BITS+PREC_W+1)'(r_prec3))
            + (FRAC_BITS+PREC_W+1)'(1 << (FRAC_BITS-1));
        num    = NUM_W'(rnd >> FRAC_BITS);
        feet_c = r_feet3;
        inch_c = r_inch3;
        num_c  = num;
        if (num >= r_prec3) begin
            num_c = '0;
            if (r_inch3 == 4'd11) begin
                inch_c = '0;
                feet_c = r_feet3 + WHOLE_W'(1);
            end else begin
                inch_c = r_inch3 + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1   <= i_length_in[31];
        r_mag1   <= i_length_in[31] ? 33'h1_0000_0000 - {1'b0, i_length_in}
                                    : {1'b0, i_length_in};
        r_scale1 <= i_scale;
        r_prec1  <= n_prec;

        r_neg2   <= r_neg1;
        r_prod2  <= r_mag1 * {33'd0, r_scale1};
        r_prec2  <= r_prec1;

        r_neg3   <= r_neg2;
        r_ovf3   <= ovf;
        r_nz3    <= sm != '0;
        r_feet3  <= feet_d;
        r_inch3  <= inch_d;
        r_frac3  <= sm[FRAC_BITS-1:0];
        r_prec3  <= r_prec2;

        o_split.neg  <= r_neg3 && r_nz3;
        o_split.ovf  <= r_ovf3;
        o_split.feet <= (feet_c > WHOLE_W'(4095)) ? FEET_W'(4095) : FEET_W'(feet_c);
        o_split.inch <= inch_c;
        o_split.num  <= num_c;
        o_split.prec <= r_prec3;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fifs_gcd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fraction reduction
// Twenty-step binary GCD pipeline (one subtract-and-shift step per stage) and
// a restoring divide of numerator and denominator by the GCD, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module fifs_gcd
    import fifs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  t_split                 i_split,
    output logic                   o_valid,
    output t_split                 o_split
);

    // Values fit in 9 bits; both operands are scaled down by their common
    // power of two first, then a binary GCD finishes on the odd part.
    localparam int GS = 2 * NUM_W + 2;
    localparam int DS = PREC_W;

    typedef struct packed {
        t_split            s;
        logic [NUM_W-1:0]  a;
        logic [NUM_W-1:0]  b;
        logic [3:0]        k;
    } t_gst;

    typedef struct packed {
        t_split            s;
        logic [PREC_W-1:0] g;
        logic [2*PREC_W-1:0] rn;
        logic [2*PREC_W-1:0] rd;
        logic [NUM_W-1:0]  qn;
        logic [PREC_W-1:0] qd;
    } t_dst;

    logic [GS:0] r_gv;
    t_gst        r_g [GS+1];
    t_gst        n_g [GS];
    logic [DS:0] r_dv;
    t_dst        r_d [DS+1];
    t_dst        n_d [DS];

    always_comb begin
        for (int i = 0; i < GS; i++) begin
            n_g[i] = r_g[i];
            if (r_g[i].a != '0 && r_g[i].b != '0) begin
                if (!r_g[i].a[0] && !r_g[i].b[0]) begin
                    n_g[i].a = r_g[i].a >> 1;
                    n_g[i].b = r_g[i].b >> 1;
                    n_g[i].k = r_g[i].k + 4'd1;
                end else if (!r_g[i].a[0]) begin
                    n_g[i].a = r_g[i].a >> 1;
                end else if (!r_g[i].b[0]) begin
                    n_g[i].b = r_g[i].b >> 1;
                end else if (r_g[i].a >= r_g[i].b) begin
                    n_g[i].a = (r_g[i].a - r_g[i].b) >> 1;
                end else begin
                    n_g[i].b = (r_g[i].b - r_g[i].a) >> 1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DS; i++) begin
            n_d[i] = r_d[i];
            n_d[i].rn = r_d[i].rn << 1;
            n_d[i].rd = r_d[i].rd << 1;
            if ((r_d[i].rn << 1) >= ({{PREC_W{1'b0}}, r_d[i].g} << PREC_W)) begin
                n_d[i].rn = (r_d[i].rn << 1) - ({{PREC_W{1'b0}}, r_d[i].g} << PREC_W);
                n_d[i].qn = NUM_W'({r_d[i].qn, 1'b1});
            end else begin
                n_d[i].qn = NUM_W'({r_d[i].qn, 1'b0});
            end
            if ((r_d[i].rd << 1) >= ({{PREC_W{1'b0}}, r_d[i].g} << PREC_W)) begin
                n_d[i].rd = (r_d[i].rd << 1) - ({{PREC_W{1'b0}}, r_d[i].g} << PREC_W);
                n_d[i].qd = PREC_W'({r_d[i].qd, 1'b1});
            end else begin
                n_d[i].qd = PREC_W'({r_d[i].qd, 1'b0});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv    <= '0;
            r_dv    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_gv    <= {r_gv[GS-1:0], i_valid};
            r_dv    <= {r_dv[DS-1:0], r_gv[GS]};
            o_valid <= r_dv[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_g[0].s <= i_split;
        r_g[0].a <= i_split.num;
        r_g[0].b <= i_split.prec;
        r_g[0].k <= '0;
        for (int i = 0; i < GS; i++) begin
            r_g[i+1] <= n_g[i];
        end
        r_d[0].s  <= r_g[GS].s;
        r_d[0].g  <= PREC_W'((r_g[GS].a | r_g[GS].b) << r_g[GS].k);
        r_d[0].rn <= (2*PREC_W)'(r_g[GS].s.num);
        r_d[0].rd <= (2*PREC_W)'(r_g[GS].s.prec);
        r_d[0].qn <= '0;
        r_d[0].qd <= '0;
        for (int i = 0; i < DS; i++) begin
            r_d[i+1] <= n_d[i];
        end
        o_split <= r_d[DS].s;
        if (r_d[DS].s.num == '0) begin
            o_split.num  <= '0;
            o_split.prec <= PREC_W'(1);
        end else begin
            o_split.num  <= r_d[DS].qn;
            o_split.prec <= r_d[DS].qd;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/feet_inch_fraction_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Feet / inch / fraction split
// Scales a signed Q16.16 length and splits it into feet, inches and a
// reduced fraction of an inch.
// ----------------------------------------------------------------------------
// A new length may be started in every cycle; busy stays low. Each result
// appears on the o_ ports with o_done high for one cycle, after the item
// passes 36 registers: four stages of scaling and splitting, twenty-one for
// the binary GCD (a load and twenty steps), ten for the divide by the GCD
// (a load and nine steps, one quotient bit each) and the output register.
// The receiver cannot stall and must take every result as it appears.
module feet_inch_fraction_split
    import fifs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [31:0]       i_length_in,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    output logic                   o_done,
    output logic                   o_is_negative,
    output logic [FEET_W-1:0]      o_feet_mag,
    output logic [3:0]             o_inch_part,
    output logic [7:0]             o_frac_num,
    output logic [PREC_W-1:0]      o_frac_den,
    output logic                   o_overflow
);

    logic [31:0]       r_scale;
    logic [PREC_W-1:0] r_prec;
    logic              split_v;
    t_split            split_s;
    t_split            red_s;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 32'd65536;
            r_prec  <= PREC_W'(16);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DRAW_SCALE: r_scale <= i_cfg_data;
                REG_FRAC_PREC:  r_prec  <= i_cfg_data[PREC_W-1:0];
                default: ;
            endcase
        end
    end

    fifs_split u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start),
        .i_length_in (i_length_in),
        .i_scale     (r_scale),
        .i_prec      (r_prec),
        .o_valid     (split_v),
        .o_split     (split_s)
    );

    fifs_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_v),
        .i_split (split_s),
        .o_valid (o_done),
        .o_split (red_s)
    );

    assign o_is_negative = red_s.neg;
    assign o_feet_mag    = red_s.feet;
    assign o_inch_part   = red_s.inch;
    assign o_frac_num    = red_s.num[7:0];
    assign o_frac_den    = red_s.prec;
    assign o_overflow    = red_s.ovf;

`ifndef SYNTHESIS
    a_inch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_inch_part <= 4'd11) else $error("inch out of range");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_frac_den != '0) else $error("zero denominator");
    a_zero_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_frac_num == '0) |-> o_frac_den == PREC_W'(1))
        else $error("zero fraction not reduced");
`endif

endmodule
`default_nettype wire
